// ===== hw/rtl/scfu_pkg.sv =====
`default_nettype none

package scfu_pkg;

  // Stack geometry
  localparam int PTR_W       = 8;
  localparam int STACK_DEPTH = 256;
  localparam int SLOT_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PTR_SPAN    = 2 ** PTR_W;

  localparam logic [PTR_W-1:0] SP_RESET   = 8'hFF;
  localparam logic [7:0]       BREAK_FLAG = 8'h10;

  // Instruction kinds
  localparam logic [2:0] MODE_JMP = 3'd0;
  localparam logic [2:0] MODE_JSR = 3'd1;
  localparam logic [2:0] MODE_BRK = 3'd2;
  localparam logic [2:0] MODE_RTI = 3'd3;
  localparam logic [2:0] MODE_RTS = 3'd4;

  // Push data select
  localparam logic [1:0] PD_HI   = 2'd0;
  localparam logic [1:0] PD_LO   = 2'd1;
  localparam logic [1:0] PD_STAT = 2'd2;

  // Load destination for the byte read in the previous step
  localparam logic [1:0] LD_NONE = 2'd0;
  localparam logic [1:0] LD_STAT = 2'd1;
  localparam logic [1:0] LD_LO   = 2'd2;

  // Result instruction pointer select
  localparam logic [1:0] IP_TARGET = 2'd0;
  localparam logic [1:0] IP_NEXT   = 2'd1;
  localparam logic [1:0] IP_VECTOR = 2'd2;
  localparam logic [1:0] IP_POPPED = 2'd3;

  // Result status select
  localparam logic [1:0] ST_IN    = 2'd0;
  localparam logic [1:0] ST_BRK   = 2'd1;
  localparam logic [1:0] ST_SAVED = 2'd2;

  // Microprogram addresses
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] UA_JMP  = 4'd0;
  localparam logic [UPC_W-1:0] UA_JSR0 = 4'd1;
  localparam logic [UPC_W-1:0] UA_JSR1 = 4'd2;
  localparam logic [UPC_W-1:0] UA_BRK0 = 4'd3;
  localparam logic [UPC_W-1:0] UA_BRK1 = 4'd4;
  localparam logic [UPC_W-1:0] UA_BRK2 = 4'd5;
  localparam logic [UPC_W-1:0] UA_RTI0 = 4'd6;
  localparam logic [UPC_W-1:0] UA_RTI1 = 4'd7;
  localparam logic [UPC_W-1:0] UA_RTI2 = 4'd8;
  localparam logic [UPC_W-1:0] UA_RTI3 = 4'd9;
  localparam logic [UPC_W-1:0] UA_RTS0 = 4'd10;
  localparam logic [UPC_W-1:0] UA_RTS1 = 4'd11;
  localparam logic [UPC_W-1:0] UA_RTS2 = 4'd12;
  localparam logic [UPC_W-1:0] UA_NOP  = 4'd13;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [1:0] push_sel;
    logic [1:0] ld_sel;
    logic       last;
    logic [1:0] ip_sel;
    logic [1:0] st_sel;
  } ctrl_t;

  typedef logic [SLOT_W-1:0] slot_table_t [PTR_SPAN];

  function automatic slot_table_t build_slot_table();
    slot_table_t t;
    for (int i = 0; i < PTR_SPAN; i++) begin
      t[i] = SLOT_W'(i % STACK_DEPTH);
    end
    return t;
  endfunction

  localparam slot_table_t SLOT_TABLE = build_slot_table();

  function automatic ctrl_t cw(logic push, logic pop, logic [1:0] push_sel,
                               logic [1:0] ld_sel, logic last,
                               logic [1:0] ip_sel, logic [1:0] st_sel);
    ctrl_t c;
    c.push     = push;
    c.pop      = pop;
    c.push_sel = push_sel;
    c.ld_sel   = ld_sel;
    c.last     = last;
    c.ip_sel   = ip_sel;
    c.st_sel   = st_sel;
    return c;
  endfunction

  // Control store
  function automatic ctrl_t ucode(logic [UPC_W-1:0] a);
    ctrl_t c;
    case (a)
      UA_JMP:  c = cw(1'b0, 1'b0, PD_HI,   LD_NONE, 1'b1, IP_TARGET, ST_IN);
      UA_JSR0: c = cw(1'b1, 1'b0, PD_HI,   LD_NONE, 1'b0, IP_TARGET, ST_IN);
      UA_JSR1: c = cw(1'b1, 1'b0, PD_LO,   LD_NONE, 1'b1, IP_TARGET, ST_IN);
      UA_BRK0: c = cw(1'b1, 1'b0, PD_HI,   LD_NONE, 1'b0, IP_VECTOR, ST_BRK);
      UA_BRK1: c = cw(1'b1, 1'b0, PD_LO,   LD_NONE, 1'b0, IP_VECTOR, ST_BRK);
      UA_BRK2: c = cw(1'b1, 1'b0, PD_STAT, LD_NONE, 1'b1, IP_VECTOR, ST_BRK);
      UA_RTI0: c = cw(1'b0, 1'b1, PD_HI,   LD_NONE, 1'b0, IP_POPPED, ST_SAVED);
      UA_RTI1: c = cw(1'b0, 1'b1, PD_HI,   LD_STAT, 1'b0, IP_POPPED, ST_SAVED);
      UA_RTI2: c = cw(1'b0, 1'b1, PD_HI,   LD_LO,   1'b0, IP_POPPED, ST_SAVED);
      UA_RTI3: c = cw(1'b0, 1'b0, PD_HI,   LD_NONE, 1'b1, IP_POPPED, ST_SAVED);
      UA_RTS0: c = cw(1'b0, 1'b1, PD_HI,   LD_NONE, 1'b0, IP_POPPED, ST_IN);
      UA_RTS1: c = cw(1'b0, 1'b1, PD_HI,   LD_LO,   1'b0, IP_POPPED, ST_IN);
      UA_RTS2: c = cw(1'b0, 1'b0, PD_HI,   LD_NONE, 1'b1, IP_POPPED, ST_IN);
      default: c = cw(1'b0, 1'b0, PD_HI,   LD_NONE, 1'b1, IP_NEXT,   ST_IN);
    endcase
    return c;
  endfunction

  // Dispatch: entry step for each instruction kind
  function automatic logic [UPC_W-1:0] mode_entry(logic [2:0] m);
    logic [UPC_W-1:0] e;
    case (m)
      MODE_JMP: e = UA_JMP;
      MODE_JSR: e = UA_JSR0;
      MODE_BRK: e = UA_BRK0;
      MODE_RTI: e = UA_RTI0;
      MODE_RTS: e = UA_RTS0;
      default:  e = UA_NOP;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/stack_control_flow_unit_top.sv =====
`default_nettype none

// Stack control-flow unit: JMP, JSR, BRK, RTI and RTS on an internal
// page-one stack of 8-bit entries.
//
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; mode, target_address, next_address and status_in are
// sampled then. busy stays high while the microprogram runs.
// Result channel: new_ip, status_out and stack_level are shown for one
// cycle with done high. The receiver cannot stall; a new command may be
// issued in the same cycle that done is shown.
// Config channel: cfg_ready is always high; cfg_data is written to the
// break vector when cfg_valid is high. Write only while idle.
//
// Timing: one microprogram step per cycle, at most one stack access per step
// on a single-port store. Steps: JMP and undefined modes 1, JSR 2, RTS 3,
// BRK 3, RTI 4. done rises at the edge that ends the last step and busy
// drops with it; a new command is taken only once busy is low.
// Reset: stack pointer 0xFF, break vector 0, every stack entry reads as
// zero until written (per-entry valid flags), no reset pass needed.

module stack_control_flow_unit_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  mode,
  input  wire logic [15:0] target_address,
  input  wire logic [15:0] next_address,
  input  wire logic [7:0]  status_in,
  output logic             done,
  output logic [15:0]      new_ip,
  output logic [7:0]       status_out,
  output logic [7:0]       stack_level,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  localparam int SW = scfu_pkg::SLOT_W;
  localparam int PW = scfu_pkg::PTR_W;

  // Sequencer state
  logic                       running;
  logic [scfu_pkg::UPC_W-1:0] upc;
  scfu_pkg::ctrl_t            ctl;

  // Latched command
  logic [15:0] target_q;
  logic [15:0] next_q;
  logic [7:0]  status_q;

  // Datapath registers
  logic [PW-1:0] sp;
  logic [PW-1:0] sp_next;
  logic [7:0]    lo_reg;
  logic [7:0]    stat_reg;
  logic [15:0]   break_vector;

  // Stack store
  logic [7:0]                       mem [scfu_pkg::STACK_DEPTH];
  logic [scfu_pkg::STACK_DEPTH-1:0] valid;
  logic [SW-1:0]                    addr;
  logic [7:0]                       wdata;
  logic                             we;
  logic                             re;
  logic [7:0]                       rdata;
  logic                             rd_valid;
  logic [7:0]                       rd_byte;

  logic [15:0] ip_value;
  logic [7:0]  st_value;
  logic        accept;

  assign accept    = start && !busy;
  assign busy      = running;
  assign cfg_ready = 1'b1;
  assign ctl       = scfu_pkg::ucode(upc);

  // Push stores at sp then decrements; pop increments then reads.
  always_comb begin
    sp_next = sp;
    if (running && ctl.push) begin
      sp_next = PW'(sp - 1'b1);
    end else if (running && ctl.pop) begin
      sp_next = PW'(sp + 1'b1);
    end
  end

  assign we   = running && ctl.push;
  assign re   = running && ctl.pop;
  assign addr = ctl.push ? scfu_pkg::SLOT_TABLE[sp] : scfu_pkg::SLOT_TABLE[PW'(sp + 1'b1)];

  always_comb begin
    case (ctl.push_sel)
      scfu_pkg::PD_HI:   wdata = next_q[15:8];
      scfu_pkg::PD_LO:   wdata = next_q[7:0];
      scfu_pkg::PD_STAT: wdata = status_q;
      default:           wdata = status_q;
    endcase
  end

  // Never-written entries read as zero
  assign rd_byte = rd_valid ? rdata : 8'h00;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[addr] <= 1'b1;
      end
      if (re) begin
        rd_valid <= valid[addr];
      end
    end
  end

  always_comb begin
    case (ctl.ip_sel)
      scfu_pkg::IP_TARGET: ip_value = target_q;
      scfu_pkg::IP_NEXT:   ip_value = next_q;
      scfu_pkg::IP_VECTOR: ip_value = break_vector;
      scfu_pkg::IP_POPPED: ip_value = {rd_byte, lo_reg};
      default:             ip_value = next_q;
    endcase
    case (ctl.st_sel)
      scfu_pkg::ST_IN:    st_value = status_q;
      scfu_pkg::ST_BRK:   st_value = status_q | scfu_pkg::BREAK_FLAG;
      scfu_pkg::ST_SAVED: st_value = stat_reg;
      default:            st_value = status_q;
    endcase
  end

  // Sequencer: dispatch on accept, advance each step, drop out on the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      upc     <= scfu_pkg::UA_NOP;
      done    <= 1'b0;
      sp      <= scfu_pkg::SP_RESET;
    end else begin
      done <= 1'b0;
      sp   <= sp_next;
      if (accept) begin
        running <= 1'b1;
        upc     <= scfu_pkg::mode_entry(mode);
      end else if (running) begin
        if (ctl.last) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          upc <= upc + 1'b1;
        end
      end
    end
  end

  // Break vector register
  always_ff @(posedge clk) begin
    if (rst) begin
      break_vector <= 16'h0000;
    end else if (cfg_valid && cfg_ready) begin
      break_vector <= cfg_data;
    end
  end

  // Payload registers: command latch, popped bytes, result
  always_ff @(posedge clk) begin
    if (accept) begin
      target_q <= target_address;
      next_q   <= next_address;
      status_q <= status_in;
    end
    if (running) begin
      case (ctl.ld_sel)
        scfu_pkg::LD_STAT: stat_reg <= rd_byte;
        scfu_pkg::LD_LO:   lo_reg   <= rd_byte;
        default: ;
      endcase
      if (ctl.last) begin
        new_ip      <= ip_value;
        status_out  <= st_value;
        stack_level <= sp_next;
      end
    end
  end

  // A result only follows a running microprogram
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(running))
    else $error("done without a running microprogram");

  // An accepted command starts the sequencer
  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    accept |=> running)
    else $error("accepted command did not start the sequencer");

  // The stack pointer only moves while a microprogram runs
  a_sp_idle: assert property (@(posedge clk) disable iff (rst)
    !running |=> $stable(sp))
    else $error("stack pointer moved while idle");

  // Results never come back to back, since a new command is taken no earlier than the done cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("results on consecutive cycles");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  // Encodings the block treats as no-ops
  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  // Allow a full microprogram plus margin
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] target;
    logic [15:0] next_addr;
    logic [7:0]  status;
  } flow_cmd_t;

  typedef struct packed {
    logic [15:0] ip;
    logic [7:0]  status;
    logic [7:0]  level;
  } flow_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  mode = '0;
  logic [15:0] target_address = '0;
  logic [15:0] next_address = '0;
  logic [7:0]  status_in = '0;
  logic        done;
  logic [15:0] new_ip;
  logic [7:0]  status_out;
  logic [7:0]  stack_level;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  // Commands waiting to be driven, and results still owed by the block
  flow_cmd_t    cmd_queue[$];
  flow_result_t expected_flow[$];

  // Shadow copy of the stack unit: pointer, page and break vector
  logic [7:0]  model_sp = scfu_pkg::SP_RESET;
  logic [7:0]  model_stack [scfu_pkg::STACK_DEPTH];
  logic [15:0] model_vector = '0;

  int gap_pct = 0;
  int queued_items = 0;
  int results_checked = 0;
  int error_count = 0;
  int vector_writes = 0;
  int mode_hits [8];

  stack_control_flow_unit_top DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .target_address (target_address),
    .next_address   (next_address),
    .status_in      (status_in),
    .done           (done),
    .new_ip         (new_ip),
    .status_out     (status_out),
    .stack_level    (stack_level),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Push stores at the pointer, then decrements; the pointer wraps at 8 bits.
  function automatic void push_stack_byte(logic [7:0] value);
    model_stack[model_sp % scfu_pkg::STACK_DEPTH] = value;
    model_sp = model_sp - 8'd1;
  endfunction

  // Pop increments first, then reads.
  function automatic logic [7:0] pop_stack_byte();
    model_sp = model_sp + 8'd1;
    return model_stack[model_sp % scfu_pkg::STACK_DEPTH];
  endfunction

  // Work out the result of one control-flow instruction and advance the shadow stack.
  function automatic flow_result_t predict_flow(flow_cmd_t c);
    flow_result_t r;
    logic [7:0]   lo;
    logic [7:0]   hi;
    r.ip     = c.next_addr;
    r.status = c.status;
    case (c.mode)
      scfu_pkg::MODE_JMP: begin
        r.ip = c.target;
      end
      scfu_pkg::MODE_JSR: begin
        push_stack_byte(c.next_addr[15:8]);
        push_stack_byte(c.next_addr[7:0]);
        r.ip = c.target;
      end
      scfu_pkg::MODE_BRK: begin
        push_stack_byte(c.next_addr[15:8]);
        push_stack_byte(c.next_addr[7:0]);
        push_stack_byte(c.status);
        r.status = c.status | scfu_pkg::BREAK_FLAG;
        r.ip     = model_vector;
      end
      scfu_pkg::MODE_RTI: begin
        r.status = pop_stack_byte();
        lo       = pop_stack_byte();
        hi       = pop_stack_byte();
        r.ip     = {hi, lo};
      end
      scfu_pkg::MODE_RTS: begin
        lo   = pop_stack_byte();
        hi   = pop_stack_byte();
        r.ip = {hi, lo};
      end
      default: begin
        // reserved encodings fall through untouched
      end
    endcase
    r.level = model_sp;
    return r;
  endfunction

  function automatic flow_cmd_t cmd(logic [2:0] m, logic [15:0] t, logic [15:0] n,
                                    logic [7:0] s);
    flow_cmd_t c;
    c.mode      = m;
    c.target    = t;
    c.next_addr = n;
    c.status    = s;
    return c;
  endfunction

  // Favor the all-zero and all-one words now and then.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic flow_cmd_t random_cmd(logic [2:0] m);
    return cmd(m, pick_word(), pick_word(), 8'(pick_word()));
  endfunction

  task automatic enqueue(flow_cmd_t c);
    cmd_queue.push_back(c);
    queued_items++;
  endtask

  // Nested calls and breaks with random content, unwound by matching returns.
  // Stray jumps and the reserved encoding 6 are sprinkled between the calls.
  task automatic queue_call_chain(int depth);
    logic [2:0] kinds[$];
    logic [2:0] k;
    for (int i = 0; i < depth; i++) begin
      k = ($urandom_range(1) != 0) ? scfu_pkg::MODE_JSR : scfu_pkg::MODE_BRK;
      kinds.push_back(k);
      enqueue(random_cmd(k));
      if ($urandom_range(4) == 0) begin
        enqueue(random_cmd(($urandom_range(1) != 0) ? scfu_pkg::MODE_JMP : MODE_RSVD6));
      end
    end
    while (kinds.size() != 0) begin
      k = kinds.pop_back();
      enqueue(random_cmd((k == scfu_pkg::MODE_JSR) ? scfu_pkg::MODE_RTS : scfu_pkg::MODE_RTI));
    end
  endtask

  // Mostly well-formed call chains, the rest any encoding at all, which
  // leaves the stack unbalanced and exercises mismatched returns.
  task automatic queue_random_phase(int count);
    int stop_at;
    stop_at = queued_items + count;
    while (queued_items < stop_at) begin
      if ($urandom_range(3) != 0) begin
        queue_call_chain($urandom_range(1, 6));
      end else begin
        repeat ($urandom_range(1, 4)) enqueue(random_cmd(3'($urandom_range(7))));
      end
    end
  endtask

  // Hold until every queued transaction is taken and its result has come back.
  task automatic drain();
    while (cmd_queue.size() != 0 || start || expected_flow.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the break vector through the config channel; the block is idle here.
  task automatic write_break_vector(logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    model_vector = cfg_data;
    vector_writes++;
    cfg_valid <= 1'b0;
  endtask

  // Command driver: record the transaction taken at this edge, then either
  // hold the current one, present the next from the queue, or idle.
  always @(posedge clk) begin : drive_commands
    flow_cmd_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_flow.push_back(
          predict_flow(cmd(mode, target_address, next_address, status_in)));
        mode_hits[mode]++;
      end
      if (!start || !busy) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
          nxt = cmd_queue.pop_front();
          start          <= 1'b1;
          mode           <= nxt.mode;
          target_address <= nxt.target;
          next_address   <= nxt.next_addr;
          status_in      <= nxt.status;
        end else begin
          // drop start and scramble the payload; the block must ignore it
          start          <= 1'b0;
          mode           <= 3'($urandom_range(7));
          target_address <= 16'($urandom);
          next_address   <= 16'($urandom);
          status_in      <= 8'($urandom);
        end
      end
    end
  end

  // Result monitor: each strobe is matched against the oldest expectation.
  always @(posedge clk) begin : check_results
    flow_result_t exp_r;
    if (!rst && done) begin
      if (expected_flow.size() == 0) begin
        $error("unexpected result: new_ip %h status_out %h stack_level %h",
               new_ip, status_out, stack_level);
        error_count++;
      end else begin
        exp_r = expected_flow.pop_front();
        results_checked++;
        if (new_ip !== exp_r.ip) begin
          $error("new_ip: expected %h, got %h", exp_r.ip, new_ip);
          error_count++;
        end
        if (status_out !== exp_r.status) begin
          $error("status_out: expected %h, got %h", exp_r.status, status_out);
          error_count++;
        end
        if (stack_level !== exp_r.level) begin
          $error("stack_level: expected %h, got %h", exp_r.level, stack_level);
          error_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < scfu_pkg::STACK_DEPTH; i++) model_stack[i] = 8'h00;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, break vector still at its reset value.
    // Returns straight out of reset pop cleared entries and wrap the pointer up.
    enqueue(cmd(scfu_pkg::MODE_RTS, 16'h1234, 16'h5678, 8'hA5));
    enqueue(cmd(scfu_pkg::MODE_RTI, 16'hFFFF, 16'hFFFF, 8'h00));
    enqueue(cmd(scfu_pkg::MODE_JMP, 16'hFFFF, 16'h0000, 8'h00));
    enqueue(cmd(scfu_pkg::MODE_JMP, 16'h0000, 16'hFFFF, 8'hFF));
    enqueue(cmd(scfu_pkg::MODE_JSR, 16'hFFFF, 16'h0000, 8'hFF));
    enqueue(cmd(scfu_pkg::MODE_JSR, 16'h0000, 16'hFFFF, 8'h00));
    // Break with the flag clear, then with every status bit set
    enqueue(cmd(scfu_pkg::MODE_BRK, 16'h0000, 16'hFFFF, 8'h00));
    enqueue(cmd(scfu_pkg::MODE_BRK, 16'hFFFF, 16'h0000, 8'hFF));
    enqueue(cmd(scfu_pkg::MODE_RTI, 16'h0000, 16'h0000, 8'h00));
    enqueue(cmd(scfu_pkg::MODE_RTI, 16'hFFFF, 16'hFFFF, 8'hFF));
    enqueue(cmd(scfu_pkg::MODE_RTS, 16'h0000, 16'h0000, 8'h00));
    enqueue(cmd(scfu_pkg::MODE_RTS, 16'hFFFF, 16'hFFFF, 8'hFF));
    // Reserved encodings pass the next address and status through
    enqueue(cmd(MODE_RSVD5, 16'hFFFF, 16'h0000, 8'hFF));
    enqueue(cmd(MODE_RSVD6, 16'h0000, 16'hFFFF, 8'h00));
    enqueue(cmd(MODE_RSVD7, 16'hA55A, 16'h5AA5, 8'h5A));
    // Mismatched pair: break unwound by a subroutine return, then pop past it
    enqueue(cmd(scfu_pkg::MODE_BRK, 16'h0F0F, 16'hBEEF, 8'h42));
    enqueue(cmd(scfu_pkg::MODE_RTS, 16'h0000, 16'h0000, 8'h00));
    enqueue(cmd(scfu_pkg::MODE_RTS, 16'h0000, 16'h0000, 8'h00));
    drain();

    // Sender idles about a third of the time, vector at all ones.
    write_break_vector(16'hFFFF);
    gap_pct = 32;
    queue_random_phase(220);
    drain();

    // Sender idles most of the time, vector random.
    write_break_vector(16'($urandom_range(1, 16'hFFFE)));
    gap_pct = 60;
    queue_random_phase(220);
    drain();

    // Back to back; a deep chain overruns the page and wraps the pointer.
    write_break_vector(16'h0000);
    gap_pct = 0;
    queue_call_chain(130);
    queue_random_phase(100);
    drain();

    if (expected_flow.size() != 0) begin
      $error("%0d results never arrived", expected_flow.size());
      error_count++;
    end
    $display("Checked %0d results over %0d break-vector settings, with the pointer wrapped",
             results_checked, vector_writes);
    $display("jmp %0d, jsr %0d, brk %0d, rti %0d, rts %0d, reserved %0d",
             mode_hits[scfu_pkg::MODE_JMP], mode_hits[scfu_pkg::MODE_JSR],
             mode_hits[scfu_pkg::MODE_BRK], mode_hits[scfu_pkg::MODE_RTI],
             mode_hits[scfu_pkg::MODE_RTS],
             mode_hits[MODE_RSVD5] + mode_hits[MODE_RSVD6] + mode_hits[MODE_RSVD7]);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #400000;
    $display("watchdog expired with %0d results outstanding", expected_flow.size());
    $display("status: fail");
    $finish;
  end

endmodule

// ===== stack_control_flow_unit_top.f =====
hw/rtl/scfu_pkg.sv
hw/rtl/stack_control_flow_unit_top.sv
bench/testbench.sv
